// ----- src/scfe_pkg.sv -----
// Shared types and constants for the scaled Chebyshev filter evaluator.
`timescale 1ns / 1ps
package scfe_pkg;

	localparam int MAX_DEGREE_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	localparam int REG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DEGREE_W = 6;
	localparam int STATUS_W = 2;
	localparam int VAL_W = 32;

	localparam logic [REG_IDX_W-1:0] REG_DEGREE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOWER  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_CUT    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_UPPER  = 2'd3;

	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_SAT   = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_DEGEN = 2'd2;

	localparam logic [DEGREE_W-1:0]     RST_DEGREE = 6'd0;
	localparam logic signed [VAL_W-1:0] RST_LOWER  = 32'sd0;
	localparam logic signed [VAL_W-1:0] RST_CUT    = 32'sd65536;
	localparam logic signed [VAL_W-1:0] RST_UPPER  = 32'sd131072;

	localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef logic signed [VAL_W-1:0] qval_t;

	// A rounded fixed-point value together with its saturation flag.
	typedef struct packed {
		logic  ov;
		qval_t val;
	} qres_t;

	typedef enum logic [2:0] {
		ST_START,
		ST_RHO,
		ST_G2,
		ST_DEN,
		ST_R2,
		ST_W,
		ST_IDLE
	} seq_state_t;

endpackage

// ----- src/scaled_chebyshev_filter_eval.sv -----
// Scaled Chebyshev filter evaluator: coefficient sequencer and per-item pipeline.
//
//  channel   | ports                                   | handshake
//  ----------+-----------------------------------------+---------------------------
//  input     | eigen_value                             | start, taken when busy low
//  result    | filter_value, status                    | done, one cycle, no stall
//  config    | cfg_index, cfg_data                     | cfg_write, taken at once
//
// An item can enter in every cycle while busy is low, and its result passes through
// 1 entry stage, 33 divider stages, 1 rounding stage, 2*(MAX_DEGREE-1) recurrence
// stages and 1 output stage, a count that does not depend on FRAC_BITS.
// Reset clears all valid bits; reset and every register write restart the coefficient
// build in one shared bit-serial divider, which holds busy high while the build runs;
// a capped degree p below two or a zero divisor ends the build sooner.
`timescale 1ns / 1ps
module scaled_chebyshev_filter_eval #(
	parameter int MAX_DEGREE = scfe_pkg::MAX_DEGREE_DEF,
	parameter int FRAC_BITS  = scfe_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [scfe_pkg::VAL_W-1:0]     eigen_value,
	output logic                                  done,
	output logic signed [scfe_pkg::VAL_W-1:0]     filter_value,
	output logic [scfe_pkg::STATUS_W-1:0]         status,
	input  logic                                  cfg_write,
	input  logic [scfe_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [scfe_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import scfe_pkg::*;

	localparam int QB  = 33;                 // quotient bits; anything larger saturates
	localparam int NMW = 34;                 // magnitude of 2x - upper - cut
	localparam int DVW = 34;                 // divisor magnitude width
	localparam int PNW = NMW + FRAC_BITS;    // per-item numerator width
	localparam int HW  = PNW - QB;
	localparam int SW  = FRAC_BITS + 35;     // serial divider numerator width
	localparam int SCW = $clog2(SW + 1);
	localparam int PW  = $clog2(MAX_DEGREE + 1);
	localparam int NC  = (MAX_DEGREE > 1) ? MAX_DEGREE - 1 : 1;
	localparam int KW  = (NC > 1) ? $clog2(NC) : 1;
	localparam int NR  = MAX_DEGREE;

	function automatic qres_t clamp_mag(input logic neg, input logic big,
			input logic [VAL_W-1:0] m);
		qres_t res;
		res.ov = 1'b0;
		res.val = qval_t'(m);
		if (neg) begin
			if (big || m > 32'h8000_0000) begin
				res.ov = 1'b1;
				res.val = Q_MIN;
			end else begin
				res.val = qval_t'(~m + 32'd1);
			end
		end else if (big || m[VAL_W-1]) begin
			res.ov = 1'b1;
			res.val = Q_MAX;
		end
		return res;
	endfunction

	function automatic qres_t qmul(input qval_t a, input qval_t b);
		logic signed [63:0] p;
		logic [63:0] mag;
		logic [63:0] mr;
		p = a * b;
		mag = p[63] ? 64'(-p) : 64'(p);
		mr = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return clamp_mag(p[63], |mr[63:32], mr[31:0]);
	endfunction

	// One restoring step: returns the quotient bit over the new remainder.
	function automatic logic [DVW:0] dstep(input logic [DVW-1:0] rem, input logic nb,
			input logic [DVW-1:0] d);
		logic [DVW:0] r2;
		logic ge;
		r2 = {rem, nb};
		ge = r2 >= {1'b0, d};
		if (ge)
			r2 = r2 - {1'b0, d};
		return {ge, r2[DVW-1:0]};
	endfunction

	function automatic qres_t qfin(input logic [QB-1:0] q, input logic [DVW-1:0] r,
			input logic [DVW-1:0] d, input logic neg, input logic of);
		logic rnd;
		logic [QB:0] m;
		qres_t res;
		rnd = r >= (d - r);
		m = {1'b0, q} + {{QB{1'b0}}, rnd};
		res = clamp_mag(neg, |m[QB:32], m[31:0]);
		if (of) begin
			res.ov = 1'b1;
			res.val = neg ? Q_MIN : Q_MAX;
		end
		return res;
	endfunction

	// Configuration registers.
	logic [DEGREE_W-1:0] degree_q;
	qval_t               lower_q, cut_q, upper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= RST_DEGREE;
			lower_q  <= RST_LOWER;
			cut_q    <= RST_CUT;
			upper_q  <= RST_UPPER;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEGREE: degree_q <= cfg_data[DEGREE_W-1:0];
				REG_LOWER:  lower_q  <= qval_t'(cfg_data);
				REG_CUT:    cut_q    <= qval_t'(cfg_data);
				REG_UPPER:  upper_q  <= qval_t'(cfg_data);
			endcase
		end
	end

	// Values derived from the registers.
	logic signed [32:0] dw_c;
	logic signed [34:0] nlo_c;
	logic [DVW-1:0]     dw_mag_c, nlo_mag_c;
	logic [PW-1:0]      p_c;
	logic               degen_c;

	always_comb begin
		dw_c = 33'(upper_q) - 33'(cut_q);
		nlo_c = (35'(lower_q) <<< 1) - 35'(upper_q) - 35'(cut_q);
		dw_mag_c = dw_c[32] ? 34'(-dw_c) : 34'(dw_c);
		nlo_mag_c = nlo_c[34] ? 34'(-nlo_c) : 34'(nlo_c);
		if (7'(degree_q) > 7'(MAX_DEGREE))
			p_c = PW'(MAX_DEGREE);
		else
			p_c = PW'(degree_q);
		degen_c = (p_c != '0) && (dw_c == '0 || nlo_c == '0);
	end

	logic [DVW-1:0] dw_mag_q, nlo_mag_q;
	logic           dw_neg_q, nlo_neg_q;
	logic [PW-1:0]  p_q;
	logic           degen_q, cov_q;
	qval_t          rho_q, g2_q, r2_q;
	logic [KW-1:0]  k_q;
	qval_t          r2_arr_q [NC];
	qval_t          w_arr_q [NC];

	// Shared bit-serial divider.
	logic [SW-1:0]  sd_num_q, sd_quo_q;
	logic [DVW-1:0] sd_den_q, sd_rem_q;
	logic           sd_neg_q, sd_run_q;
	logic [SCW-1:0] sd_cnt_q;
	logic           sd_done;
	logic           sd_rnd;
	logic [SW:0]    sd_m;
	qres_t          sd_res;
	logic [DVW:0]   sd_step;

	logic           ld_go, ld_neg;
	logic [NMW-1:0] ld_mag;
	logic [6:0]     ld_sh;
	logic [DVW-1:0] ld_den;

	seq_state_t     state_q, state_d;
	logic signed [32:0] den_c;
	logic [DVW-1:0] den_mag_c;
	logic           k_last;
	qres_t          w_res;

	always_comb begin
		sd_done = sd_run_q && sd_cnt_q == '0;
		sd_rnd = sd_rem_q >= (sd_den_q - sd_rem_q);
		sd_m = {1'b0, sd_quo_q} + {{SW{1'b0}}, sd_rnd};
		sd_res = clamp_mag(sd_neg_q, |sd_m[SW:32], sd_m[31:0]);
		sd_step = dstep(sd_rem_q, sd_num_q[SW-1], sd_den_q);
		den_c = 33'(g2_q) - 33'(rho_q);
		den_mag_c = den_c[32] ? 34'(-den_c) : 34'(den_c);
		k_last = ((PW+1)'(k_q) + (PW+1)'(2)) >= {1'b0, p_q};
		w_res = qmul(rho_q, r2_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_START: state_d = (degen_c || p_c < PW'(2)) ? ST_IDLE : ST_RHO;
			ST_RHO:   if (sd_done) state_d = ST_G2;
			ST_G2:    if (sd_done) state_d = ST_DEN;
			ST_DEN:   state_d = (den_c == '0) ? ST_IDLE : ST_R2;
			ST_R2:    if (sd_done) state_d = ST_W;
			ST_W:     state_d = k_last ? ST_IDLE : ST_DEN;
			ST_IDLE:  state_d = ST_IDLE;
			default:  state_d = ST_START;
		endcase
		if (cfg_write)
			state_d = ST_START;
	end

	always_comb begin
		ld_go = 1'b0;
		ld_mag = dw_mag_c;
		ld_sh = 7'(FRAC_BITS);
		ld_den = nlo_mag_c;
		ld_neg = dw_c[32] ^ nlo_c[34];
		busy = state_q != ST_IDLE;
		unique case (state_q)
			ST_START: ld_go = !(degen_c || p_c < PW'(2));
			ST_RHO: begin
				ld_go = sd_done;
				ld_mag = nlo_mag_q;
				ld_sh = 7'(FRAC_BITS + 1);
				ld_den = dw_mag_q;
				ld_neg = dw_neg_q ^ nlo_neg_q;
			end
			ST_DEN: begin
				ld_go = den_c != '0;
				ld_mag = NMW'(1);
				ld_sh = 7'(2 * FRAC_BITS);
				ld_den = den_mag_c;
				ld_neg = den_c[32];
			end
			default: ld_go = 1'b0;
		endcase
		if (cfg_write)
			ld_go = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_START;
			sd_run_q <= 1'b0;
			sd_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (ld_go) begin
				sd_run_q <= 1'b1;
				sd_cnt_q <= SCW'(SW);
			end else if (cfg_write || sd_done) begin
				sd_run_q <= 1'b0;
			end else if (sd_run_q) begin
				sd_cnt_q <= sd_cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld_go) begin
			sd_num_q <= SW'(ld_mag) << ld_sh;
			sd_den_q <= ld_den;
			sd_neg_q <= ld_neg;
			sd_rem_q <= '0;
			sd_quo_q <= '0;
		end else if (sd_run_q && sd_cnt_q != '0) begin
			sd_num_q <= sd_num_q << 1;
			sd_rem_q <= sd_step[DVW-1:0];
			sd_quo_q <= {sd_quo_q[SW-2:0], sd_step[DVW]};
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_START: begin
				dw_mag_q  <= dw_mag_c;
				dw_neg_q  <= dw_c[32];
				nlo_mag_q <= nlo_mag_c;
				nlo_neg_q <= nlo_c[34];
				p_q       <= p_c;
				degen_q   <= degen_c;
				cov_q     <= 1'b0;
			end
			ST_RHO: if (sd_done) begin
				rho_q <= sd_res.val;
				cov_q <= cov_q | sd_res.ov;
			end
			ST_G2: if (sd_done) begin
				g2_q  <= sd_res.val;
				cov_q <= cov_q | sd_res.ov;
				k_q   <= '0;
			end
			ST_DEN: if (den_c == '0) degen_q <= 1'b1;
			ST_R2: if (sd_done) begin
				r2_q <= sd_res.val;
				r2_arr_q[k_q] <= sd_res.val;
				cov_q <= cov_q | sd_res.ov;
			end
			ST_W: begin
				w_arr_q[k_q] <= w_res.val;
				cov_q <= cov_q | w_res.ov;
				rho_q <= r2_q;
				if (!k_last)
					k_q <= k_q + 1'b1;
			end
			default: ;
		endcase
	end

	// Per-item pipeline: entry, two parallel restoring dividers, rounding.
	logic signed [34:0] nx_c;
	logic [NMW-1:0]     nx_mag_c;
	logic [PNW-1:0]     n_c;
	logic [HW-1:0]      hi_c;
	logic               accept;

	always_comb begin
		accept = start && !busy;
		nx_c = (35'(eigen_value) <<< 1) - 35'(upper_q) - 35'(cut_q);
		nx_mag_c = nx_c[34] ? 34'(-nx_c) : 34'(nx_c);
		n_c = PNW'(nx_mag_c) << FRAC_BITS;
		hi_c = n_c[PNW-1:QB];
	end

	logic           dv_v_s  [QB+1];
	logic           dv_ng_s [QB+1];
	logic [QB-1:0]  dv_lo_s [QB+1];
	logic [DVW-1:0] dv_r1_s [QB+1];
	logic [DVW-1:0] dv_r2_s [QB+1];
	logic [QB-1:0]  dv_q1_s [QB+1];
	logic [QB-1:0]  dv_q2_s [QB+1];
	logic           dv_o1_s [QB+1];
	logic           dv_o2_s [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_v_s[0] <= 1'b0;
		else
			dv_v_s[0] <= accept;
	end

	always_ff @(posedge clk) begin
		dv_ng_s[0] <= nx_c[34];
		dv_lo_s[0] <= n_c[QB-1:0];
		dv_r1_s[0] <= DVW'(hi_c);
		dv_r2_s[0] <= DVW'(hi_c);
		dv_o1_s[0] <= DVW'(hi_c) >= nlo_mag_q;
		dv_o2_s[0] <= DVW'(hi_c) >= dw_mag_q;
		dv_q1_s[0] <= '0;
		dv_q2_s[0] <= '0;
	end

	for (genvar j = 0; j < QB; j++) begin : g_div
		logic [DVW:0] st1, st2;
		always_comb begin
			st1 = dstep(dv_r1_s[j], dv_lo_s[j][QB-1], nlo_mag_q);
			st2 = dstep(dv_r2_s[j], dv_lo_s[j][QB-1], dw_mag_q);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[j+1] <= 1'b0;
			else
				dv_v_s[j+1] <= dv_v_s[j];
		end
		always_ff @(posedge clk) begin
			dv_ng_s[j+1] <= dv_ng_s[j];
			dv_lo_s[j+1] <= dv_lo_s[j] << 1;
			dv_r1_s[j+1] <= st1[DVW-1:0];
			dv_r2_s[j+1] <= st2[DVW-1:0];
			dv_q1_s[j+1] <= {dv_q1_s[j][QB-2:0], st1[DVW]};
			dv_q2_s[j+1] <= {dv_q2_s[j][QB-2:0], st2[DVW]};
			dv_o1_s[j+1] <= dv_o1_s[j];
			dv_o2_s[j+1] <= dv_o2_s[j];
		end
	end

	// Recurrence stages; rc index i holds C_{i+1} and C_i.
	logic  rc_v_s   [NR];
	qval_t rc_cur_s [NR];
	qval_t rc_prv_s [NR];
	qval_t rc_lin_s [NR];
	logic  rc_ov_s  [NR];

	qres_t c1_res, lin_res;

	always_comb begin
		c1_res = qfin(dv_q1_s[QB], dv_r1_s[QB], nlo_mag_q, dv_ng_s[QB] ^ nlo_neg_q,
			dv_o1_s[QB]);
		lin_res = qfin(dv_q2_s[QB], dv_r2_s[QB], dw_mag_q, dv_ng_s[QB] ^ dw_neg_q,
			dv_o2_s[QB]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rc_v_s[0] <= 1'b0;
		else
			rc_v_s[0] <= dv_v_s[QB];
	end

	always_ff @(posedge clk) begin
		rc_cur_s[0] <= c1_res.val;
		rc_prv_s[0] <= qval_t'(33'sd1 <<< FRAC_BITS);
		rc_lin_s[0] <= lin_res.val;
		rc_ov_s[0]  <= c1_res.ov | ((p_q >= PW'(2)) & (lin_res.ov | cov_q));
	end

	logic  ra_v_s   [NC];
	qval_t ra_a_s   [NC];
	qval_t ra_u_s   [NC];
	qval_t ra_cur_s [NC];
	qval_t ra_prv_s [NC];
	qval_t ra_lin_s [NC];
	logic  ra_ov_s  [NC];

	for (genvar i = 0; i < MAX_DEGREE - 1; i++) begin : g_rec
		logic  act;
		qres_t a_res, u_res, t_res;
		logic signed [33:0] diff;
		qres_t n_res;
		always_comb begin
			act = (PW+1)'(p_q) >= (PW+1)'(i + 2);
			a_res = qmul(r2_arr_q[i], rc_lin_s[i]);
			u_res = qmul(w_arr_q[i], rc_prv_s[i]);
			t_res = qmul(ra_a_s[i], ra_cur_s[i]);
			diff = (34'(t_res.val) <<< 1) - 34'(ra_u_s[i]);
			n_res.ov = 1'b0;
			n_res.val = qval_t'(diff);
			if (diff > 34'(Q_MAX)) begin
				n_res.ov = 1'b1;
				n_res.val = Q_MAX;
			end else if (diff < 34'(Q_MIN)) begin
				n_res.ov = 1'b1;
				n_res.val = Q_MIN;
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ra_v_s[i]   <= 1'b0;
				rc_v_s[i+1] <= 1'b0;
			end else begin
				ra_v_s[i]   <= rc_v_s[i];
				rc_v_s[i+1] <= ra_v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			ra_a_s[i]   <= a_res.val;
			ra_u_s[i]   <= u_res.val;
			ra_cur_s[i] <= rc_cur_s[i];
			ra_prv_s[i] <= rc_prv_s[i];
			ra_lin_s[i] <= rc_lin_s[i];
			ra_ov_s[i]  <= rc_ov_s[i] | (act & (a_res.ov | u_res.ov));
			rc_lin_s[i+1] <= ra_lin_s[i];
			if (act) begin
				rc_cur_s[i+1] <= n_res.val;
				rc_prv_s[i+1] <= ra_cur_s[i];
				rc_ov_s[i+1]  <= ra_ov_s[i] | t_res.ov | n_res.ov;
			end else begin
				rc_cur_s[i+1] <= ra_cur_s[i];
				rc_prv_s[i+1] <= ra_prv_s[i];
				rc_ov_s[i+1]  <= ra_ov_s[i];
			end
		end
	end

	// Output register; degree zero and degenerate settings override the value.
	logic                done_q;
	qval_t               value_q;
	logic [STATUS_W-1:0] status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= rc_v_s[NR-1];
	end

	always_ff @(posedge clk) begin
		if (p_q == '0) begin
			value_q  <= qval_t'(33'sd1 <<< FRAC_BITS);
			status_q <= STAT_OK;
		end else if (degen_q) begin
			value_q  <= '0;
			status_q <= STAT_DEGEN;
		end else begin
			value_q  <= rc_cur_s[NR-1];
			status_q <= rc_ov_s[NR-1] ? STAT_SAT : STAT_OK;
		end
	end

	assign done = done_q;
	assign filter_value = value_q;
	assign status = status_q;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the scaled Chebyshev filter evaluator.
`timescale 1ns / 1ps
module tb_top;
	import scfe_pkg::*;

	typedef struct {
		qval_t                val;
		logic [STATUS_W-1:0]  st;
	} filter_result_t;

	class filter_scoreboard;
		logic [DEGREE_W-1:0] deg_r;
		qval_t lo_r, ct_r, up_r;
		filter_result_t pending_q[$];
		int errors;
		bit ovf;

		function new();
			deg_r = RST_DEGREE;
			lo_r = RST_LOWER;
			ct_r = RST_CUT;
			up_r = RST_UPPER;
			errors = 0;
		endfunction

		function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_DEGREE: deg_r = data[DEGREE_W-1:0];
				REG_LOWER:  lo_r = data;
				REG_CUT:    ct_r = data;
				REG_UPPER:  up_r = data;
			endcase
		endfunction

		function longint clamp_mag(bit neg, longint unsigned m);
			if (neg) begin
				if (m > 64'd2147483648) begin
					ovf = 1;
					return -64'sd2147483648;
				end
				return -longint'(m);
			end
			if (m > 64'd2147483647) begin
				ovf = 1;
				return 64'sd2147483647;
			end
			return longint'(m);
		endfunction

		// Rounded quotient num * 2^sh / den, ties away from zero.
		function longint fx_div(longint num, longint den, int sh);
			bit neg;
			longint unsigned n, d, q, r;
			neg = (num < 0) != (den < 0);
			n = (num < 0) ? -num : num;
			d = (den < 0) ? -den : den;
			n = n << sh;
			q = n / d;
			r = n % d;
			if (r >= d - r)
				q++;
			if (q == 0)
				return 0;
			return clamp_mag(neg, q);
		endfunction

		function longint fx_mul(longint a, longint b);
			longint prod;
			longint unsigned m;
			prod = a * b;
			m = (prod < 0) ? -prod : prod;
			m = (m + (64'd1 << (FRAC_BITS_DEF - 1))) >> FRAC_BITS_DEF;
			if (m == 0)
				return 0;
			return clamp_mag(prod < 0, m);
		endfunction

		function filter_result_t eval_filter(qval_t ev);
			filter_result_t res;
			longint one, dw, nlo, nx, cur, prv, rho, g2, lin, den, r2, t, u, nxt;
			int p;
			one = 64'sd1 <<< FRAC_BITS_DEF;
			ovf = 0;
			p = deg_r;
			if (p > MAX_DEGREE_DEF)
				p = MAX_DEGREE_DEF;
			res.val = 0;
			res.st = STAT_DEGEN;
			if (p == 0) begin
				res.val = one;
				res.st = STAT_OK;
				return res;
			end
			dw = longint'(up_r) - longint'(ct_r);
			nlo = 2 * longint'(lo_r) - up_r - ct_r;
			nx = 2 * longint'(ev) - up_r - ct_r;
			if (dw == 0 || nlo == 0)
				return res;
			cur = fx_div(nx, nlo, FRAC_BITS_DEF);
			if (p >= 2) begin
				prv = one;
				rho = fx_div(dw, nlo, FRAC_BITS_DEF);
				g2 = fx_div(nlo, dw, FRAC_BITS_DEF + 1);
				lin = fx_div(nx, dw, FRAC_BITS_DEF);
				for (int k = 2; k <= p; k++) begin
					den = g2 - rho;
					if (den == 0)
						return res;
					r2 = fx_div(1, den, 2 * FRAC_BITS_DEF);
					t = fx_mul(fx_mul(r2, lin), cur);
					u = fx_mul(fx_mul(rho, r2), prv);
					nxt = 2 * t - u;
					if (nxt > 64'sd2147483647) begin
						ovf = 1;
						nxt = 64'sd2147483647;
					end else if (nxt < -64'sd2147483648) begin
						ovf = 1;
						nxt = -64'sd2147483648;
					end
					prv = cur;
					cur = nxt;
					rho = r2;
				end
			end
			res.val = cur[VAL_W-1:0];
			res.st = ovf ? STAT_SAT : STAT_OK;
			return res;
		endfunction

		function void note_item(qval_t ev);
			pending_q.insert(pending_q.size(), eval_filter(ev));
		endfunction

		function void check_result(qval_t val, logic [STATUS_W-1:0] st);
			filter_result_t want;
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected result value %h status %0d", $time, val, st);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (val !== want.val) begin
				$display("%0t: filter_value expected %h actual %h", $time, want.val, val);
				errors++;
			end
			if (st !== want.st) begin
				$display("%0t: status expected %0d actual %0d", $time, want.st, st);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	qval_t eigen_value = '0;
	logic done;
	qval_t filter_value;
	logic [STATUS_W-1:0] status;
	logic cfg_write = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	filter_scoreboard sb = new();
	int idle_pct;

	scaled_chebyshev_filter_eval uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.eigen_value(eigen_value), .done(done), .filter_value(filter_value),
		.status(status), .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (start && !busy)
			sb.note_item(eigen_value);
		if (done)
			sb.check_result(filter_value, status);
	end

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic configure(int deg, qval_t lo, qval_t ct, qval_t up);
		write_reg(REG_DEGREE, deg);
		write_reg(REG_LOWER, lo);
		write_reg(REG_CUT, ct);
		write_reg(REG_UPPER, up);
		cfg_write <= 1'b0;
	endtask

	task automatic send_item(qval_t ev);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		eigen_value <= ev;
		do @(posedge clk); while (busy);
	endtask

	// After the last expected result, wait a while longer so that a stray result is caught.
	task automatic drain();
		start <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (110) @(posedge clk);
	endtask

	function automatic qval_t pick_point(qval_t lo, qval_t up);
		longint a, b, v;
		if ($urandom_range(3) == 0)
			return $urandom;
		a = (lo < up) ? lo : up;
		b = (lo < up) ? up : lo;
		v = a - (b - a) / 4 + longint'($urandom) % ((b - a) * 3 / 2 + 1);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[VAL_W-1:0];
	endfunction

	initial begin
		int deg, n, sent;
		qval_t lo, ct, up;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 0;
		@(posedge clk);

		// Reset values: degree zero gives one whatever the point.
		send_item(32'sh8000_0000);
		send_item(32'sh7FFF_FFFF);
		send_item(0);
		drain();
		configure(1, RST_LOWER, RST_CUT, RST_UPPER);
		send_item(32'sh0001_8000);
		send_item(32'sh8000_0000);
		drain();
		configure(32, -32'sd65536, RST_CUT, 32'sd262144);
		send_item(32'sh0002_0000);
		send_item(32'sh0000_8000);
		drain();
		configure(63, -32'sd65536, RST_CUT, 32'sd262144);
		send_item(32'sh0001_8000);
		drain();
		// Zero half-width, then normalisation point at the centre.
		configure(3, 0, 32'sd65536, 32'sd65536);
		send_item(5);
		drain();
		configure(3, 32'sd98304, 32'sd65536, 32'sd131072);
		send_item(5);
		drain();
		// Tiny interval and a far point force saturation.
		configure(1, 1, 0, 1);
		send_item(32'sh7FFF_FFFF);
		send_item(32'sh8000_0000);
		drain();
		configure(5, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
		send_item(32'sh7FFF_FFFF);
		send_item(0);
		drain();

		sent = 0;
		while (sent < 1400) begin
			case ($urandom_range(3))
				0: idle_pct = 0;
				1: idle_pct = 53;
				default: idle_pct = 23;
			endcase
			deg = ($urandom_range(5) == 0) ? $urandom_range(63) : $urandom_range(12);
			if ($urandom_range(4) == 0) begin
				lo = $urandom;
				ct = $urandom;
				up = $urandom;
			end else begin
				ct = $signed($urandom_range(32'h0040_0000)) - 32'sh0020_0000;
				up = ct + $signed($urandom_range(32'h0020_0000, 1));
				lo = ct - $signed($urandom_range(32'h0020_0000, 1));
			end
			configure(deg, lo, ct, up);
			n = $urandom_range(40, 10);
			for (int i = 0; i < n; i++)
				send_item(pick_point(lo, up));
			sent += n;
			drain();
		end

		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end
endmodule

// ----- sim.f -----
src/scfe_pkg.sv
src/scaled_chebyshev_filter_eval.sv
tb/tb_top.sv
